>>> sv/nqbs_pkg.sv
`default_nettype none
package nqbs_pkg;

  localparam int MaxBoard = 16;
  localparam int RowW     = $clog2(MaxBoard);
  localparam int CntW     = RowW + 1;
  localparam int MoveW    = 32;
  localparam int CfgW     = 5;
  localparam int CfgReset = 8;

  // Write side of the board store: one row-column write and one tries write a cycle.
  typedef struct packed {
    logic            col_we;
    logic [RowW-1:0] col_addr;
    logic [RowW-1:0] col_data;
    logic            tries_we;
    logic [RowW-1:0] tries_addr;
    logic [CntW-1:0] tries_data;
  } store_wr_t;

  // Clamp the configured size into 1..MaxBoard.
  function automatic logic [CntW-1:0] eff_size(input logic [CfgW-1:0] bs);
    logic [CntW-1:0] s;
    if (bs == '0) begin
      s = CntW'(1);
    end else if (bs > CfgW'(MaxBoard)) begin
      s = CntW'(MaxBoard);
    end else begin
      s = CntW'(bs);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/nqbs_board_store.sv
`default_nettype none
module nqbs_board_store
  import nqbs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire store_wr_t       wr_i,
  input  wire logic [RowW-1:0] col_raddr_i,
  input  wire logic [RowW-1:0] tries_raddr_i,
  output logic      [RowW-1:0] col_rdata_o,
  output logic      [CntW-1:0] tries_rdata_o
);

  logic [RowW-1:0] row_col_q [MaxBoard];
  logic [CntW-1:0] tries_q   [MaxBoard];

  // Column store: contents only meaningful once loaded.
  always_ff @(posedge clk_i) begin
    if (wr_i.col_we) begin
      row_col_q[wr_i.col_addr] <= wr_i.col_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxBoard; i++) begin
        tries_q[i] <= '0;
      end
    end else if (wr_i.tries_we) begin
      tries_q[wr_i.tries_addr] <= wr_i.tries_data;
    end
  end

  assign col_rdata_o   = row_col_q[col_raddr_i];
  assign tries_rdata_o = tries_q[tries_raddr_i];

endmodule
`default_nettype wire

>>> sv/nqbs_attack_check.sv
`default_nettype none
module nqbs_attack_check
  import nqbs_pkg::*;
(
  input  wire logic [RowW-1:0] cand_col_i,
  input  wire logic [RowW-1:0] placed_col_i,
  input  wire logic [RowW-1:0] row_dist_i,
  output logic                 hit_o
);

  logic [CntW-1:0] cand_w;
  logic [CntW-1:0] placed_w;
  logic [CntW-1:0] dist_w;

  assign cand_w   = CntW'(cand_col_i);
  assign placed_w = CntW'(placed_col_i);
  assign dist_w   = CntW'(row_dist_i);

  // Same column, or either diagonal at the given row distance.
  assign hit_o = (placed_w == cand_w) ||
                 ((placed_w + dist_w) == cand_w) ||
                 ((cand_w + dist_w) == placed_w);

endmodule
`default_nettype wire

>>> sv/n_queens_backtrack_solver_core.sv
`default_nettype none
// Channel   Signals                                           Transfer
// input     in_valid_i / in_ready_o, start_column_i           valid & ready
// output    out_valid_o / out_ready_i, row_index_o, column_o,
//           solved_o, move_count_o, last_result_o             valid & ready
// config    cfg_we_i, cfg_wdata_i (board size)                write on cfg_we_i
//
// Loading stores one row item per transfer; the completing item leads to a start step
// and a depth-first search around one shared attack compare unit. Testing row d runs a
// fetch step, up to one compare per earlier row and a descend step once all pass, so
// search time depends on the data. in_ready_o stays low from search start until the
// last result is registered, and results leave one per cycle while out_ready_i is
// high. Reset sets the board size to 8 and clears counters.
module n_queens_backtrack_solver_core
  import nqbs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [RowW-1:0]  start_column_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [RowW-1:0]  row_index_o,
  output logic      [RowW-1:0]  column_o,
  output logic                  solved_o,
  output logic      [MoveW-1:0] move_count_o,
  output logic                  last_result_o
);

  typedef enum logic [2:0] {
    StLoad,
    StStart,
    StFetch,
    StCheck,
    StAdvance,
    StBack,
    StEmit
  } state_e;

  state_e           state_q, state_d;
  logic [CfgW-1:0]  bsize_q;
  logic [CntW-1:0]  loaded_q, loaded_d;
  logic [CntW-1:0]  depth_q, depth_d;
  logic [RowW-1:0]  scan_q, scan_d;
  logic [RowW-1:0]  cur_q, cur_d;
  logic [MoveW-1:0] moves_q, moves_d;
  logic             solved_q, solved_d;
  logic [RowW-1:0]  emit_q, emit_d;

  logic             out_valid_q, out_valid_d;
  logic [RowW-1:0]  row_index_q, row_index_d;
  logic [RowW-1:0]  column_q, column_d;
  logic             solved_out_q, solved_out_d;
  logic [MoveW-1:0] move_count_q, move_count_d;
  logic             last_q, last_d;

  logic [CntW-1:0]  size;
  store_wr_t        wr;
  logic [RowW-1:0]  col_raddr;
  logic [RowW-1:0]  col_rdata;
  logic [CntW-1:0]  tries_rdata;
  logic             hit;
  logic [RowW-1:0]  row_dist;
  logic [CntW-1:0]  loaded_next;
  logic [CntW-1:0]  depth_next;
  logic [CntW-1:0]  tries_next;
  logic [CntW-1:0]  emit_next;
  logic             in_accept;

  assign size       = eff_size(bsize_q);
  assign in_ready_o = (state_q == StLoad);
  assign in_accept  = in_valid_i && in_ready_o;

  assign row_dist    = depth_q[RowW-1:0] - scan_q;
  assign depth_next  = depth_q + CntW'(1);
  assign tries_next  = tries_rdata - CntW'(1);
  assign emit_next   = CntW'(emit_q) + CntW'(1);
  assign loaded_next = (loaded_q == '1) ? loaded_q : loaded_q + CntW'(1);

  nqbs_board_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr),
    .col_raddr_i   (col_raddr),
    .tries_raddr_i (depth_q[RowW-1:0]),
    .col_rdata_o   (col_rdata),
    .tries_rdata_o (tries_rdata)
  );

  nqbs_attack_check u_check (
    .cand_col_i   (cur_q),
    .placed_col_i (col_rdata),
    .row_dist_i   (row_dist),
    .hit_o        (hit)
  );

  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    depth_d      = depth_q;
    scan_d       = scan_q;
    cur_d        = cur_q;
    moves_d      = moves_q;
    solved_d     = solved_q;
    emit_d       = emit_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    row_index_d  = row_index_q;
    column_d     = column_q;
    solved_out_d = solved_out_q;
    move_count_d = move_count_q;
    last_d       = last_q;
    wr           = '0;
    col_raddr    = depth_q[RowW-1:0];

    unique case (state_q)
      StLoad: begin
        if (in_accept) begin
          // Rows past the store depth are counted but not kept.
          wr.col_we   = (loaded_q < CntW'(MaxBoard));
          wr.col_addr = loaded_q[RowW-1:0];
          wr.col_data = start_column_i;
          loaded_d    = loaded_next;
          if (loaded_next >= size) begin
            state_d = StStart;
          end
        end
      end
      StStart: begin
        moves_d         = '0;
        depth_d         = '0;
        wr.tries_we     = 1'b1;
        wr.tries_addr   = '0;
        wr.tries_data   = size;
        state_d         = StFetch;
      end
      StFetch: begin
        // Past the last row: every row placed.
        if (depth_q >= size) begin
          solved_d = 1'b1;
          emit_d   = '0;
          state_d  = StEmit;
        end else begin
          cur_d   = col_rdata;
          scan_d  = '0;
          state_d = StCheck;
        end
      end
      StCheck: begin
        col_raddr = scan_q;
        if (CntW'(scan_q) == depth_q) begin
          // Safe against all earlier rows: descend.
          depth_d = depth_next;
          if (depth_next < size) begin
            wr.tries_we   = 1'b1;
            wr.tries_addr = depth_next[RowW-1:0];
            wr.tries_data = size;
          end
          state_d = StFetch;
        end else if (hit) begin
          state_d = StAdvance;
        end else begin
          scan_d = scan_q + RowW'(1);
        end
      end
      StAdvance: begin
        // Step the column cyclically and spend one try.
        wr.col_we   = 1'b1;
        wr.col_addr = depth_q[RowW-1:0];
        if ((CntW'(cur_q) + CntW'(1)) >= size) begin
          wr.col_data = '0;
        end else begin
          wr.col_data = cur_q + RowW'(1);
        end
        cur_d         = wr.col_data;
        moves_d       = (moves_q == '1) ? moves_q : moves_q + MoveW'(1);
        wr.tries_we   = 1'b1;
        wr.tries_addr = depth_q[RowW-1:0];
        wr.tries_data = tries_next;
        if (tries_next == '0) begin
          if (depth_q == '0) begin
            solved_d = 1'b0;
            emit_d   = '0;
            state_d  = StEmit;
          end else begin
            depth_d = depth_q - CntW'(1);
            state_d = StBack;
          end
        end else begin
          scan_d  = '0;
          state_d = StCheck;
        end
      end
      StBack: begin
        // Reload the previous row's column, then advance it.
        cur_d   = col_rdata;
        state_d = StAdvance;
      end
      StEmit: begin
        col_raddr = emit_q;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          row_index_d  = emit_q;
          column_d     = col_rdata;
          solved_out_d = solved_q;
          move_count_d = moves_q;
          last_d       = (emit_next == size);
          emit_d       = emit_q + RowW'(1);
          if (emit_next == size) begin
            loaded_d = '0;
            depth_d  = '0;
            state_d  = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Result payload holds while the consumer stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      bsize_q      <= CfgW'(CfgReset);
      loaded_q     <= '0;
      depth_q      <= '0;
      moves_q      <= '0;
      solved_q     <= 1'b0;
      emit_q       <= '0;
      scan_q       <= '0;
      cur_q        <= '0;
      out_valid_q  <= 1'b0;
      row_index_q  <= '0;
      column_q     <= '0;
      solved_out_q <= 1'b0;
      move_count_q <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
      end
      loaded_q     <= loaded_d;
      depth_q      <= depth_d;
      moves_q      <= moves_d;
      solved_q     <= solved_d;
      emit_q       <= emit_d;
      scan_q       <= scan_d;
      cur_q        <= cur_d;
      out_valid_q  <= out_valid_d;
      row_index_q  <= row_index_d;
      column_q     <= column_d;
      solved_out_q <= solved_out_d;
      move_count_q <= move_count_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = row_index_q;
  assign column_o      = column_q;
  assign solved_o      = solved_out_q;
  assign move_count_o  = move_count_q;
  assign last_result_o = last_q;

endmodule
`default_nettype wire
